>>> hw/rtl/lut_bilinear_remap_unit_defines.svh
// Assertion macros for the checker file of the bilinear remap unit.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef LUT_BILINEAR_REMAP_UNIT_DEFINES_SVH
`define LUT_BILINEAR_REMAP_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LBR_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lbr_checker: same-cycle property failed");

// The consequent must hold in the cycle after the antecedent.
`define LBR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lbr_checker: next-cycle property failed");

`endif

>>> hw/rtl/lbr_pkg.sv
// Shared types and constants of the bilinear remap unit.
// No dependencies; all files of the block but lbr_ram and the defines header import it.
`timescale 1ns / 1ps
`default_nettype none

package lbr_pkg;

  // Request codes.
  localparam logic [1:0] REQ_PIXEL  = 2'd0;
  localparam logic [1:0] REQ_WEIGHT = 2'd1;
  localparam logic [1:0] REQ_CALC   = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_SKIP  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_SAT   = 2'd3;

  // Configuration register indexes.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  localparam int FRAME_DIM_RESET = 1024;
  localparam int DIM_MIN         = 2;

  // Arithmetic constants.
  localparam int WEIGHTS_PER_STEP = 4;
  localparam int ROUND_BIAS       = 16384;
  localparam int WEIGHT_SHIFT     = 15;
  localparam int PIX_MAX          = 255;
  localparam int PROD_W           = 24;
  localparam int SUM_W            = 27;

  // Queue between the front and the back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int FILL_W      = QCNT_W + 1;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [9:0]  src_x;
    logic [9:0]  src_y;
    logic [7:0]  pixel_in;
    logic [11:0] weight_addr;
    logic [15:0] weight_in;
    logic [9:0]  frac_index;
    logic [9:0]  dest_col;
  } lbr_req_t;

  typedef struct packed {
    logic [7:0] pixel_out;
    logic [1:0] status;
  } lbr_res_t;

  // One classified request with its fetched neighborhood and weights.
  // pix order: above left, above right, below left, below right.
  typedef struct packed {
    logic             calc;
    logic [1:0]       status;
    logic [3:0][7:0]  pix;
    logic [3:0][15:0] wt;
  } lbr_work_t;

endpackage

`default_nettype wire

>>> hw/rtl/lbr_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module lbr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write first in program order; a read in a later cycle sees the new data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> hw/rtl/lbr_front.sv
// Front of the remap unit: configuration, request classification, memory access.
// Depends on lbr_pkg and lbr_ram (four frame banks, four weight banks).
`timescale 1ns / 1ps
`default_nettype none

module lbr_front
  import lbr_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int FRAC_STEPS = 1024
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  output logic                       full,
  input  wire lbr_req_t              item,
  input  wire logic                  cfg_valid,
  input  wire logic                  cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic [QCNT_W-1:0]     q_count,
  output logic                       work_valid,
  output lbr_work_t                  work
);

  localparam int W_BITS  = $clog2(MAX_WIDTH + 1);
  localparam int H_BITS  = $clog2(MAX_HEIGHT + 1);
  localparam int WH_BITS = (W_BITS > H_BITS) ? W_BITS : H_BITS;
  localparam int DIM_W   = ((WH_BITS > CFG_DATA_W) ? WH_BITS : CFG_DATA_W) + 1;

  localparam int W_RESET = (FRAME_DIM_RESET > MAX_WIDTH) ? MAX_WIDTH : FRAME_DIM_RESET;
  localparam int H_RESET = (FRAME_DIM_RESET > MAX_HEIGHT) ? MAX_HEIGHT : FRAME_DIM_RESET;

  // The frame is split into four banks by column and row parity.
  localparam int HALF_W   = (MAX_WIDTH + 1) / 2;
  localparam int HALF_H   = (MAX_HEIGHT + 1) / 2;
  localparam int FB_DEPTH = HALF_W * HALF_H;
  localparam int FB_AW    = (FB_DEPTH > 1) ? $clog2(FB_DEPTH) : 1;

  localparam int WT_DEPTH = WEIGHTS_PER_STEP * FRAC_STEPS;
  localparam int WT_AW    = $clog2(FRAC_STEPS);

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DATA_W-1:0] v,
                                                 input logic [DIM_W-1:0] hi);
    logic [DIM_W-1:0] ve;
    ve = DIM_W'(v);
    if (ve < DIM_W'(DIM_MIN)) begin
      return DIM_W'(DIM_MIN);
    end
    if (ve > hi) begin
      return hi;
    end
    return ve;
  endfunction

  function automatic logic [FB_AW-1:0] fb_addr(input logic [9:0] row, input logic [9:0] col);
    return FB_AW'(32'(row) * 32'(HALF_W) + 32'(col));
  endfunction

  logic [DIM_W-1:0] w_eff;
  logic [DIM_W-1:0] w_last;
  logic [DIM_W-1:0] h_eff;
  logic [DIM_W-1:0] w_cfg;
  logic [DIM_W-1:0] h_cfg;

  // Effective dimensions are clamped once, when the register is written.
  assign w_cfg = clamp_dim(cfg_data, DIM_W'(MAX_WIDTH));
  assign h_cfg = clamp_dim(cfg_data, DIM_W'(MAX_HEIGHT));

  always_ff @(posedge clk) begin
    if (rst) begin
      w_eff  <= DIM_W'(W_RESET);
      w_last <= DIM_W'(W_RESET - 1);
      h_eff  <= DIM_W'(H_RESET);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FRAME_WIDTH: begin
          w_eff  <= w_cfg;
          w_last <= w_cfg - DIM_W'(1);
        end
        REG_FRAME_HEIGHT: begin
          h_eff <= h_cfg;
        end
        default: begin
        end
      endcase
    end
  end

  logic             accept;
  logic [DIM_W-1:0] sx_e;
  logic [DIM_W-1:0] sy_e;
  logic [DIM_W-1:0] sx1;
  logic [DIM_W-1:0] sy1;
  logic [DIM_W-1:0] dcol_e;
  logic             wt_addr_ok;
  logic             frac_ok;
  logic [1:0]       st;
  logic             calc;
  logic             pix_we;
  logic             wt_we;

  assign accept     = push && !full;
  assign sx_e       = DIM_W'(item.src_x);
  assign sy_e       = DIM_W'(item.src_y);
  assign sx1        = sx_e + DIM_W'(1);
  assign sy1        = sy_e + DIM_W'(1);
  assign dcol_e     = DIM_W'(item.dest_col);
  assign wt_addr_ok = 32'(item.weight_addr) < 32'(WT_DEPTH);
  assign frac_ok    = 32'(item.frac_index) < 32'(FRAC_STEPS);

  // Classify the request; the checks for a compute go in priority order.
  always_comb begin
    st     = ST_OK;
    calc   = 1'b0;
    pix_we = 1'b0;
    wt_we  = 1'b0;
    case (item.req_type)
      REQ_PIXEL: begin
        if (sx_e < w_eff && sy_e < h_eff) begin
          pix_we = accept;
        end else begin
          st = ST_RANGE;
        end
      end
      REQ_WEIGHT: begin
        if (wt_addr_ok) begin
          wt_we = accept;
        end else begin
          st = ST_RANGE;
        end
      end
      REQ_CALC: begin
        if (dcol_e >= w_eff) begin
          st = ST_RANGE;
        end else if (dcol_e == w_last) begin
          st = ST_SKIP;
        end else if (item.src_x == 10'd0 && item.src_y == 10'd0) begin
          st = ST_SKIP;
        end else if (sx1 >= w_eff || sy1 >= h_eff) begin
          st = ST_RANGE;
        end else if (!frac_ok) begin
          st = ST_RANGE;
        end else begin
          calc = 1'b1;
        end
      end
      default: begin
        st = ST_RANGE;
      end
    endcase
  end

  // Bank coordinates. Even banks take (v+1)>>1, odd banks take v>>1.
  logic [10:0]      sx_inc;
  logic [10:0]      sy_inc;
  logic [9:0]       col_b [2];
  logic [9:0]       row_b [2];
  logic [1:0]       wr_bank;
  logic [FB_AW-1:0] fb_waddr;
  logic [FB_AW-1:0] fb_raddr [4];
  logic [7:0]       fb_rdata [4];
  logic [15:0]      wt_rdata [4];

  assign sx_inc   = {1'b0, item.src_x} + 11'd1;
  assign sy_inc   = {1'b0, item.src_y} + 11'd1;
  assign col_b[0] = sx_inc[10:1];
  assign col_b[1] = {1'b0, item.src_x[9:1]};
  assign row_b[0] = sy_inc[10:1];
  assign row_b[1] = {1'b0, item.src_y[9:1]};
  assign wr_bank  = {item.src_y[0], item.src_x[0]};
  assign fb_waddr = fb_addr({1'b0, item.src_y[9:1]}, {1'b0, item.src_x[9:1]});

  // Frame banks: bank index is {row parity, column parity}.
  for (genvar b = 0; b < 4; b++) begin : g_fb
    assign fb_raddr[b] = fb_addr(row_b[b / 2], col_b[b % 2]);

    lbr_ram #(
      .WIDTH (8),
      .DEPTH (FB_DEPTH)
    ) u_ram (
      .clk   (clk),
      .we    (pix_we && (wr_bank == 2'(b))),
      .waddr (fb_waddr),
      .wdata (item.pixel_in),
      .raddr (fb_raddr[b]),
      .rdata (fb_rdata[b])
    );
  end

  // Weight banks: bank k holds entries 4*i+k at address i.
  for (genvar k = 0; k < WEIGHTS_PER_STEP; k++) begin : g_wt
    lbr_ram #(
      .WIDTH (16),
      .DEPTH (FRAC_STEPS)
    ) u_ram (
      .clk   (clk),
      .we    (wt_we && (item.weight_addr[1:0] == 2'(k))),
      .waddr (WT_AW'(item.weight_addr[11:2])),
      .wdata (item.weight_in),
      .raddr (WT_AW'(item.frac_index)),
      .rdata (wt_rdata[k])
    );
  end

  // Tag stage aligned with the registered memory read data.
  logic       s1_valid;
  logic [1:0] s1_status;
  logic       s1_calc;
  logic       s1_x0;
  logic       s1_y0;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_status <= st;
      s1_calc   <= calc;
      s1_x0     <= item.src_x[0];
      s1_y0     <= item.src_y[0];
    end
  end

  // Put the banked pixels back into neighborhood order.
  always_comb begin
    work.calc   = s1_calc;
    work.status = s1_status;
    work.pix[0] = fb_rdata[{s1_y0, s1_x0}];
    work.pix[1] = fb_rdata[{s1_y0, !s1_x0}];
    work.pix[2] = fb_rdata[{!s1_y0, s1_x0}];
    work.pix[3] = fb_rdata[{!s1_y0, !s1_x0}];
    for (int k = 0; k < WEIGHTS_PER_STEP; k++) begin
      work.wt[k] = wt_rdata[k];
    end
  end

  assign work_valid = s1_valid;

  // Admit a request only when the queue can hold it behind the one in flight.
  assign full = ({1'b0, q_count} + FILL_W'(s1_valid)) >= FILL_W'(QUEUE_DEPTH);

endmodule

`default_nettype wire

>>> hw/rtl/lbr_queue.sv
// Short queue that decouples the front from the back of the remap unit.
// Depends on lbr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lbr_queue
  import lbr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire lbr_work_t         din,
  input  wire logic              pop,
  output lbr_work_t              dout,
  output logic                   empty,
  output logic [QCNT_W-1:0]      count
);

  lbr_work_t         mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic              do_pop;

  assign do_pop = pop && !empty;
  assign empty  = (count == QCNT_W'(0));
  assign dout   = mem[rd_ptr];

  // Pointer and fill count updates.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (!push && do_pop) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/lbr_back.sv
// Back of the remap unit: weighted sum, rounding, saturation and result register.
// Depends on lbr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lbr_back
  import lbr_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      q_empty,
  input  wire lbr_work_t q_data,
  output logic           q_pop,
  output logic           empty,
  input  wire logic      pop,
  output lbr_res_t       result
);

  logic                   b1_valid;
  logic                   b1_calc;
  logic [1:0]             b1_status;
  logic [3:0][PROD_W-1:0] b1_prod;
  logic                   o_valid;
  logic                   o_ready;
  logic                   b1_ready;

  assign o_ready  = !o_valid || pop;
  assign b1_ready = !b1_valid || o_ready;
  assign q_pop    = !q_empty && b1_ready;
  assign empty    = !o_valid;

  // Stage one: the four pixel-weight products.
  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid <= 1'b0;
    end else if (b1_ready) begin
      b1_valid <= q_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      b1_calc   <= q_data.calc;
      b1_status <= q_data.status;
      for (int k = 0; k < WEIGHTS_PER_STEP; k++) begin
        b1_prod[k] <= {16'd0, q_data.pix[k]} * {8'd0, q_data.wt[k]};
      end
    end
  end

  // Stage two: sum, round, shift and saturate.
  logic [SUM_W-1:0]            sum;
  logic [SUM_W-WEIGHT_SHIFT-1:0] rnd;

  assign sum = SUM_W'(b1_prod[0]) + SUM_W'(b1_prod[1]) + SUM_W'(b1_prod[2])
             + SUM_W'(b1_prod[3]) + SUM_W'(ROUND_BIAS);
  assign rnd = sum[SUM_W-1:WEIGHT_SHIFT];

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (o_ready) begin
      o_valid <= b1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (o_ready && b1_valid) begin
      if (!b1_calc) begin
        result.pixel_out <= 8'd0;
        result.status    <= b1_status;
      end else if (rnd > (SUM_W - WEIGHT_SHIFT)'(PIX_MAX)) begin
        result.pixel_out <= 8'(PIX_MAX);
        result.status    <= ST_SAT;
      end else begin
        result.pixel_out <= rnd[7:0];
        result.status    <= ST_OK;
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/lut_bilinear_remap_unit.sv
// Top level of the lookup-table bilinear remap unit.
// Depends on lbr_pkg, lbr_ram, lbr_front, lbr_queue and lbr_back.
//
// Channel   Direction  Handshake            Payload
// item      in         push / full          lbr_req_t (request type, coordinates, data)
// result    out        empty / pop          lbr_res_t (pixel_out, status)
// cfg       in         cfg_valid/cfg_ready  cfg_index, cfg_data (frame_width, frame_height)
//
// One request is taken per clock while full is low; the four-way banked frame store
// and the four weight banks each serve one read per cycle, which sets that rate.
// A request passes the tag stage, the queue, the product stage and the result register.
// Reset clears only control state; both stores are valid once written.
// A stalled output backs up into a four-entry queue before full rises.
`timescale 1ns / 1ps
`default_nettype none

module lut_bilinear_remap_unit
  import lbr_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int FRAC_STEPS = 1024
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  output logic                       full,
  input  wire lbr_req_t              item,
  output logic                       empty,
  input  wire logic                  pop,
  output lbr_res_t                   result,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic              work_valid;
  lbr_work_t         work;
  lbr_work_t         q_data;
  logic              q_empty;
  logic              q_pop;
  logic [QCNT_W-1:0] q_count;

  // Register writes are always taken.
  assign cfg_ready = 1'b1;

  lbr_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .FRAC_STEPS (FRAC_STEPS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .item       (item),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .q_count    (q_count),
    .work_valid (work_valid),
    .work       (work)
  );

  lbr_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (work_valid),
    .din   (work),
    .pop   (q_pop),
    .dout  (q_data),
    .empty (q_empty),
    .count (q_count)
  );

  lbr_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_data  (q_data),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

endmodule

`default_nettype wire

>>> hw/rtl/lbr_checker.sv
// Port-level checks for the bilinear remap unit, bound to its top level.
// Depends on lbr_pkg and lut_bilinear_remap_unit_defines.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "lut_bilinear_remap_unit_defines.svh"

module lbr_checker
  import lbr_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst,
  input wire logic     empty,
  input wire logic     pop,
  input wire lbr_res_t result
);

  logic skip_or_range;

  assign skip_or_range = (result.status == ST_SKIP) || (result.status == ST_RANGE);

  // A saturated result always carries the top pixel value.
  `LBR_ASSERT_IMP(a_sat_pixel, !empty && result.status == ST_SAT, result.pixel_out == 8'hFF)

  // Skipped and rejected requests never carry a pixel.
  `LBR_ASSERT_IMP(a_zero_pixel, !empty && skip_or_range, result.pixel_out == 8'd0)

  // Nothing is waiting right after reset.
  `LBR_ASSERT_IMP(a_empty_after_rst, $past(rst), empty)

  // A result that is not taken stays put.
  `LBR_ASSERT_NEXT(a_hold_result, !empty && !pop, !empty && $stable(result))

endmodule

bind lut_bilinear_remap_unit lbr_checker u_checker (.*);

`default_nettype wire

>>> tb/sv/testbench.sv
// Self-checking testbench for the lookup-table bilinear remap unit.
// Depends on lbr_pkg and lut_bilinear_remap_unit; it predicts every result in
// its own model of the frame store and weight table and checks each one.
`timescale 1ns / 1ps

module testbench;
  import lbr_pkg::*;

  localparam int MAX_DIM       = 1024;
  localparam int FRAC_STEPS    = 1024;
  localparam int FRAME_STRIDE  = MAX_DIM;
  localparam int WT_DEPTH      = WEIGHTS_PER_STEP * FRAC_STEPS;
  localparam int WEIGHT_ONE    = 32768;
  localparam int SETTLE_CYCLES = 16;
  localparam int LONG_HOLD     = 300;
  localparam int MAX_REPORTS   = 200;
  localparam longint TIMEOUT_NS = 4_000_000;

  // The request type that the block does not implement.
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  lbr_req_t item = '0;
  logic empty;
  logic pop = 1'b0;
  lbr_res_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Requests waiting to be offered and results waiting to come back.
  lbr_req_t requests_to_send[$];
  lbr_res_t remap_results_due[$];
  lbr_res_t want_res;

  // Predicted contents of the block, with its register copies.
  logic [7:0] frame_mem [int];
  logic [15:0] weight_mem [0:WT_DEPTH-1];
  logic [CFG_DATA_W-1:0] width_reg = CFG_DATA_W'(FRAME_DIM_RESET);
  logic [CFG_DATA_W-1:0] height_reg = CFG_DATA_W'(FRAME_DIM_RESET);

  // Entries the generated stream has written so far.
  bit pix_seen [int];
  bit wt_seen [0:WT_DEPTH-1];
  int gen_count = 0;

  int send_pct = 0;
  int recv_pct = 0;
  int mismatch_count = 0;

  // Long receiver hold-off, started by toggling hold_go.
  bit hold_go = 1'b0;
  bit hold_seen = 1'b0;
  int hold_left = 0;

  lut_bilinear_remap_unit #(
    .MAX_WIDTH(MAX_DIM),
    .MAX_HEIGHT(MAX_DIM),
    .FRAC_STEPS(FRAC_STEPS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .item(item),
    .empty(empty),
    .pop(pop),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // Effective frame dimension after clamping a register value.
  function automatic int eff_dim(input logic [CFG_DATA_W-1:0] v);
    if (v < DIM_MIN) return DIM_MIN;
    if (v > MAX_DIM) return MAX_DIM;
    return int'(v);
  endfunction

  // Predicts the result of one request and applies its writes.
  function automatic lbr_res_t remap_predict(input lbr_req_t r);
    int w, h, sx, sy, base;
    int unsigned acc, rounded;
    lbr_res_t res;
    w = eff_dim(width_reg);
    h = eff_dim(height_reg);
    sx = int'(r.src_x);
    sy = int'(r.src_y);
    res.pixel_out = '0;
    res.status = ST_OK;
    case (r.req_type)
      REQ_PIXEL: begin
        if (sx < w && sy < h) frame_mem[sy * FRAME_STRIDE + sx] = r.pixel_in;
        else res.status = ST_RANGE;
      end
      REQ_WEIGHT: begin
        if (int'(r.weight_addr) < WT_DEPTH) weight_mem[r.weight_addr] = r.weight_in;
        else res.status = ST_RANGE;
      end
      REQ_CALC: begin
        if (int'(r.dest_col) >= w) begin
          res.status = ST_RANGE;
        end else if (int'(r.dest_col) == w - 1) begin
          res.status = ST_SKIP;
        end else if (sx == 0 && sy == 0) begin
          res.status = ST_SKIP;
        end else if (sx + 1 >= w || sy + 1 >= h) begin
          res.status = ST_RANGE;
        end else if (int'(r.frac_index) >= FRAC_STEPS) begin
          res.status = ST_RANGE;
        end else begin
          base = int'(r.frac_index) * WEIGHTS_PER_STEP;
          acc = frame_mem[sy * FRAME_STRIDE + sx] * weight_mem[base]
              + frame_mem[sy * FRAME_STRIDE + sx + 1] * weight_mem[base + 1]
              + frame_mem[(sy + 1) * FRAME_STRIDE + sx] * weight_mem[base + 2]
              + frame_mem[(sy + 1) * FRAME_STRIDE + sx + 1] * weight_mem[base + 3];
          rounded = (acc + ROUND_BIAS) >> WEIGHT_SHIFT;
          if (rounded > PIX_MAX) begin
            res.pixel_out = 8'(PIX_MAX);
            res.status = ST_SAT;
          end else begin
            res.pixel_out = rounded[7:0];
          end
        end
      end
      default: res.status = ST_RANGE;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_REPORTS) $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  // Request builders; fields that the request type ignores stay random.
  function automatic lbr_req_t rand_req();
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    return raw[$bits(lbr_req_t)-1:0];
  endfunction

  function automatic lbr_req_t mk_pixel(input int x, input int y, input int v);
    lbr_req_t r;
    r = rand_req();
    r.req_type = REQ_PIXEL;
    r.src_x = x[9:0];
    r.src_y = y[9:0];
    r.pixel_in = v[7:0];
    return r;
  endfunction

  function automatic lbr_req_t mk_weight(input int a, input int v);
    lbr_req_t r;
    r = rand_req();
    r.req_type = REQ_WEIGHT;
    r.weight_addr = a[11:0];
    r.weight_in = v[15:0];
    return r;
  endfunction

  function automatic lbr_req_t mk_calc(input int x, input int y, input int f, input int d);
    lbr_req_t r;
    r = rand_req();
    r.req_type = REQ_CALC;
    r.src_x = x[9:0];
    r.src_y = y[9:0];
    r.frac_index = f[9:0];
    r.dest_col = d[9:0];
    return r;
  endfunction

  // Coordinate in [0, hi], biased toward the low corner and the far edge.
  function automatic int pick_coord(input int hi);
    case ($urandom_range(3))
      0: return $urandom_range((hi < 7) ? hi : 7);
      1: return hi;
      default: return $urandom_range(hi);
    endcase
  endfunction

  // Queues a request and records which store entries it loads.
  task automatic emit(input lbr_req_t r);
    int w, h;
    w = eff_dim(width_reg);
    h = eff_dim(height_reg);
    requests_to_send.insert(requests_to_send.size(), r);
    case (r.req_type)
      REQ_PIXEL: begin
        if (int'(r.src_x) < w && int'(r.src_y) < h) begin
          pix_seen[int'(r.src_y) * FRAME_STRIDE + int'(r.src_x)] = 1'b1;
          gen_count++;
        end
      end
      REQ_WEIGHT: begin
        wt_seen[r.weight_addr] = 1'b1;
        gen_count++;
      end
      REQ_CALC: gen_count++;
      default: ;
    endcase
  endtask

  // Queues a compute; if it will fetch, missing neighbors and weights go first.
  task automatic emit_calc(input lbr_req_t r);
    int w, h, x, y, base;
    w = eff_dim(width_reg);
    h = eff_dim(height_reg);
    if (int'(r.dest_col) < w && int'(r.dest_col) != w - 1 &&
        !(r.src_x == 0 && r.src_y == 0) &&
        int'(r.src_x) + 1 < w && int'(r.src_y) + 1 < h &&
        int'(r.frac_index) < FRAC_STEPS) begin
      base = int'(r.frac_index) * WEIGHTS_PER_STEP;
      for (int i = 0; i < 4; i++) begin
        x = int'(r.src_x) + i % 2;
        y = int'(r.src_y) + i / 2;
        if (!pix_seen.exists(y * FRAME_STRIDE + x)) emit(mk_pixel(x, y, $urandom_range(255)));
        if (!wt_seen[base + i]) emit(mk_weight(base + i, $urandom_range(WEIGHT_ONE / 2)));
      end
    end
    emit(r);
  endtask

  // Random traffic, mostly load-then-compute sequences, the rest noise.
  task automatic gen_random(input int n);
    int w, h, stop, k, sx, sy, f, base, a, b, c;
    lbr_req_t r;
    w = eff_dim(width_reg);
    h = eff_dim(height_reg);
    stop = gen_count + n;
    while (gen_count < stop) begin
      k = $urandom_range(99);
      if (k < 45) begin
        sx = pick_coord(w - 2);
        sy = pick_coord(h - 2);
        case ($urandom_range(3))
          0: f = $urandom_range(7);
          1: f = FRAC_STEPS - 1;
          default: f = $urandom_range(FRAC_STEPS - 1);
        endcase
        base = f * WEIGHTS_PER_STEP;
        if ($urandom_range(9) < 4) begin
          case ($urandom_range(2))
            0: begin
              // Weights that sum to unity.
              a = $urandom_range(WEIGHT_ONE);
              b = $urandom_range(WEIGHT_ONE - a);
              c = $urandom_range(WEIGHT_ONE - a - b);
              emit(mk_weight(base, a));
              emit(mk_weight(base + 1, b));
              emit(mk_weight(base + 2, c));
              emit(mk_weight(base + 3, WEIGHT_ONE - a - b - c));
            end
            1: for (int i = 0; i < 4; i++) emit(mk_weight(base + i, $urandom_range(65535)));
            default: for (int i = 0; i < 4; i++) emit(mk_weight(base + i, $urandom_range(4095)));
          endcase
        end
        if ($urandom_range(9) < 3) begin
          for (int i = 0; i < 4; i++) emit(mk_pixel(sx + i % 2, sy + i / 2, $urandom_range(255)));
        end
        emit_calc(mk_calc(sx, sy, f, pick_coord(w - 2)));
      end else if (k < 60) begin
        r = rand_req();
        r.req_type = REQ_CALC;
        emit_calc(r);
      end else if (k < 72) begin
        if ($urandom_range(1) == 0) r = mk_pixel($urandom_range(w - 1), $urandom_range(h - 1),
                                                 $urandom_range(255));
        else r = mk_pixel($urandom_range(1023), $urandom_range(1023), $urandom_range(255));
        emit(r);
      end else if (k < 82) begin
        emit(mk_weight($urandom_range(WT_DEPTH - 1), $urandom_range(65535)));
      end else if (k < 87) begin
        r = rand_req();
        r.req_type = REQ_UNUSED;
        emit(r);
      end else begin
        // Computes aimed at the skip and range checks.
        r = mk_calc(pick_coord(w - 2), pick_coord(h - 2), $urandom_range(FRAC_STEPS - 1),
                    pick_coord(w - 2));
        case ($urandom_range(4))
          0: r.dest_col = 10'(w - 1);
          1: if (w < MAX_DIM) r.dest_col = 10'($urandom_range(MAX_DIM - 1, w));
          2: begin
            r.src_x = '0;
            r.src_y = '0;
          end
          3: r.src_x = 10'(w - 1);
          default: r.src_y = 10'(h - 1);
        endcase
        emit_calc(r);
      end
    end
  endtask

  // Writes one register through the configuration channel.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_FRAME_WIDTH) width_reg = val[CFG_DATA_W-1:0];
    else height_reg = val[CFG_DATA_W-1:0];
  endtask

  // Waits until every request is sent and every result has come back.
  task automatic wait_drained();
    @(negedge clk);
    while (requests_to_send.size() != 0 || push || remap_results_due.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input int w, input int h, input int s_pct, input int r_pct,
                           input int n, input bit pause, input bit hold);
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
    send_pct <= s_pct;
    recv_pct <= r_pct;
    if (hold) hold_go <= ~hold_go;
    if (pause) begin
      gen_random(n / 2);
      wait_drained();
      gen_random(n - n / 2);
    end else begin
      gen_random(n);
    end
    wait_drained();
  endtask

  // Request driver: offers queued requests and predicts each accepted one.
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) remap_results_due.insert(remap_results_due.size(), remap_predict(item));
      if (!push || !full) begin
        if (requests_to_send.size() != 0 && $urandom_range(99) >= send_pct) begin
          push <= 1'b1;
          item <= requests_to_send.pop_front();
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Receiver hold-off counter.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_go != hold_seen) begin
      hold_seen <= hold_go;
      hold_left <= LONG_HOLD;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Result monitor: compares each popped result with the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (remap_results_due.size() == 0) begin
          report_mismatch($sformatf("unexpected result pixel_out %0d status %0d",
                                    result.pixel_out, result.status));
        end else begin
          want_res = remap_results_due.pop_front();
          if (result.pixel_out !== want_res.pixel_out)
            report_mismatch($sformatf("pixel_out %0d, predicted %0d",
                                      result.pixel_out, want_res.pixel_out));
          if (result.status !== want_res.status)
            report_mismatch($sformatf("status %0d, predicted %0d",
                                      result.status, want_res.status));
        end
      end
      pop <= (hold_left == 0) && ($urandom_range(99) >= recv_pct);
    end
  end

  // Stimulus sequence.
  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: saturating patch at the far corner with the last weight set.
    emit(mk_pixel(1022, 1022, 255));
    emit(mk_pixel(1023, 1022, 255));
    emit(mk_pixel(1022, 1023, 255));
    emit(mk_pixel(1023, 1023, 255));
    for (int i = 0; i < 4; i++) emit(mk_weight(WT_DEPTH - 4 + i, 65535));
    emit_calc(mk_calc(1022, 1022, FRAC_STEPS - 1, 1022));
    // Unity weight on the top-left neighbor.
    emit(mk_weight(0, WEIGHT_ONE));
    emit(mk_weight(1, 0));
    emit(mk_weight(2, 0));
    emit(mk_weight(3, 0));
    emit(mk_pixel(1, 0, 200));
    emit(mk_pixel(2, 0, 10));
    emit(mk_pixel(1, 1, 20));
    emit(mk_pixel(2, 1, 30));
    emit_calc(mk_calc(1, 0, 0, 5));
    // Zero map, last column, neighborhood off the right and bottom edges.
    emit_calc(mk_calc(0, 0, 0, 0));
    emit_calc(mk_calc(1, 0, 0, MAX_DIM - 1));
    emit_calc(mk_calc(MAX_DIM - 1, 5, 0, 0));
    emit_calc(mk_calc(5, MAX_DIM - 1, 0, 0));
    begin
      lbr_req_t r;
      r = rand_req();
      r.req_type = REQ_UNUSED;
      emit(r);
    end
    wait_drained();

    run_phase(640, 480, 0, 0, 110, 1'b1, 1'b0);
    run_phase(2047, 1024, 80, 0, 110, 1'b0, 1'b0);
    run_phase(2, 1024, 0, 80, 100, 1'b0, 1'b0);
    run_phase(0, 1, 21, 21, 50, 1'b0, 1'b0);
    run_phase(1024, 2, 21, 21, 90, 1'b0, 1'b0);
    run_phase($urandom_range(2, 1024), $urandom_range(2, 1024), 0, 0, 150, 1'b0, 1'b1);
    run_phase(1024, 1024, 21, 21, 120, 1'b0, 1'b0);

    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #(TIMEOUT_NS);
    $display("FAILED: results differ");
    $finish;
  end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/lbr_pkg.sv
hw/rtl/lbr_ram.sv
hw/rtl/lbr_front.sv
hw/rtl/lbr_queue.sv
hw/rtl/lbr_back.sv
hw/rtl/lut_bilinear_remap_unit.sv
hw/rtl/lbr_checker.sv
tb/sv/testbench.sv
